>>> rtl/core/utf8t_pkg.sv
// Shared types and byte-class constants for the UTF-8 character-limit truncator.
// No dependencies; every other file in rtl/core except utf8t_if imports this package.
package utf8t_pkg;

  // Byte classes: (byte & MASK) == VAL
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] ASCII_VAL  = 8'h00;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_VAL   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;

  localparam logic [7:0]  NUL_BYTE    = 8'h00;
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  // One finished character (or the terminator), queued for serialization
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final byte
    logic            eos;       // terminator record
  } utf8t_rec_t;

endpackage

>>> rtl/core/utf8t_if.sv
// Valid/ready channel interfaces for the truncator's byte input and result output.
// No dependencies.
interface utf8t_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8t_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_string;
  logic       last_of_run;

  modport source (output valid, output out_byte, output end_of_string,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input end_of_string,
                  input last_of_run, output ready);
endinterface

>>> rtl/core/utf8t_front.sv
// Front end: accepts input bytes, classifies them, buffers partial characters
// and pushes finished characters as records. Depends on utf8t_pkg, utf8t_if.
module utf8t_front
  import utf8t_pkg::*;
#(
  parameter int CHAR_COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  utf8t_in_if.sink         in_ch,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             q_full_i,
  output logic             push_o,
  output utf8t_rec_t       rec_o
);

  localparam int CmpW = (CHAR_COUNT_BITS > 16) ? CHAR_COUNT_BITS : 16;
  localparam logic [CHAR_COUNT_BITS-1:0] CountMax = {CHAR_COUNT_BITS{1'b1}};

  logic [15:0]                char_limit_q;
  logic [2:0][7:0]            pend_q, pend_d;
  logic [1:0]                 pending_q, pending_d;
  logic [1:0]                 expected_q, expected_d;
  logic [CHAR_COUNT_BITS-1:0] kept_q, kept_d;
  logic                       stopped_q, stopped_d;

  logic [7:0] b;
  logic       fire;
  logic       at_limit;
  logic       bump;

  assign in_ch.ready = !q_full_i;
  assign fire        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign at_limit    = CmpW'(kept_q) >= CmpW'(char_limit_q);

  always_comb begin
    pend_d     = pend_q;
    pending_d  = pending_q;
    expected_d = expected_q;
    kept_d     = kept_q;
    stopped_d  = stopped_q;
    push_o     = 1'b0;
    bump       = 1'b0;
    rec_o      = '0;
    if (fire) begin
      if (b == NUL_BYTE) begin
        // terminator: emit and clear string state
        push_o      = 1'b1;
        rec_o.eos   = 1'b1;
        pending_d   = '0;
        expected_d  = '0;
        kept_d      = '0;
        stopped_d   = 1'b0;
      end else if (stopped_q) begin
        // drop
      end else if (expected_q == 2'd0) begin
        if (at_limit) begin
          stopped_d = 1'b1;
        end else if ((b & ASCII_MASK) == ASCII_VAL) begin
          push_o         = 1'b1;
          rec_o.bytes[0] = b;
          bump           = 1'b1;
        end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
          pend_d[0]  = b;
          pending_d  = 2'd1;
          expected_d = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
          pend_d[0]  = b;
          pending_d  = 2'd1;
          expected_d = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
          pend_d[0]  = b;
          pending_d  = 2'd1;
          expected_d = 2'd3;
        end else begin
          stopped_d = 1'b1;
        end
      end else if ((b & CONT_MASK) != CONT_VAL) begin
        // broken sequence: drop the partial character
        pending_d  = '0;
        expected_d = '0;
        stopped_d  = 1'b1;
      end else if (pending_q >= expected_q) begin
        // final continuation: buffered bytes then this one
        push_o         = 1'b1;
        rec_o.bytes[0] = pend_q[0];
        rec_o.bytes[1] = (pending_q == 2'd1) ? b : pend_q[1];
        rec_o.bytes[2] = (pending_q == 2'd2) ? b : pend_q[2];
        rec_o.bytes[3] = b;
        rec_o.last_idx = pending_q;
        pending_d      = '0;
        expected_d     = '0;
        bump           = 1'b1;
      end else begin
        case (pending_q)
          2'd1:    pend_d[1] = b;
          2'd2:    pend_d[2] = b;
          default: pend_d[0] = b;
        endcase
        pending_d = pending_q + 2'd1;
      end
    end
    if (bump && kept_q != CountMax) begin
      kept_d = kept_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_limit_q <= LIMIT_RESET;
      pending_q    <= '0;
      expected_q   <= '0;
      kept_q       <= '0;
      stopped_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        char_limit_q <= cfg_wdata_i;
      end
      pending_q  <= pending_d;
      expected_q <= expected_d;
      kept_q     <= kept_d;
      stopped_q  <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // an open character never holds more bytes than its lead announced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (expected_q != 2'd0) |-> (pending_q != 2'd0 && pending_q <= expected_q))
    else $error("front: pending count out of range for open character");

endmodule

>>> rtl/core/utf8t_fifo.sv
// Short record queue between the front end and the serializer.
// Depends on utf8t_pkg.
module utf8t_fifo
  import utf8t_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  utf8t_rec_t rec_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       valid_o,
  output utf8t_rec_t rec_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  utf8t_rec_t            mem_q [DEPTH];
  logic [PtrW-1:0]       wptr_q, wptr_d;
  logic [PtrW-1:0]       rptr_q, rptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("fifo: occupancy exceeds depth");

endmodule

>>> rtl/core/utf8t_back.sv
// Back end: serializes the queued head record into result transfers.
// Depends on utf8t_pkg, utf8t_if.
module utf8t_back
  import utf8t_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rec_valid_i,
  input  utf8t_rec_t rec_i,
  output logic       pop_o,
  utf8t_out_if.source out_ch
);

  logic [1:0] idx_q, idx_d;
  logic       fire;
  logic       last;

  assign last                 = (idx_q == rec_i.last_idx);
  assign out_ch.valid         = rec_valid_i;
  assign out_ch.out_byte      = rec_i.bytes[idx_q];
  assign out_ch.end_of_string = rec_i.eos;
  assign out_ch.last_of_run   = last;
  assign fire                 = out_ch.valid && out_ch.ready;
  assign pop_o                = fire && last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i |-> (idx_q <= rec_i.last_idx))
    else $error("back: byte index ran past end of record");

endmodule

>>> rtl/core/utf8_char_limit_truncator_unit.sv
// A byte that completes a character (or a zero byte) is written as a record into the
//   queue, and its result run is served from the queue head, oldest record first.
// Throughput: one input byte per cycle while the queue is not full; one result per cycle
//   from the serializer while ready is high, decoupled by a QUEUE_DEPTH record queue.
// Reset: clears string state and queue, the character limit returns to 65535;
//   no clearing pass.
module utf8_char_limit_truncator_unit
  import utf8t_pkg::*;
#(
  parameter int CHAR_COUNT_BITS = 16,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  utf8t_in_if.sink     in_ch,
  utf8t_out_if.source  out_ch,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);

  // Record path: front pushes whole characters, back drains them byte by byte
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_valid;
  utf8t_rec_t push_rec;
  utf8t_rec_t head_rec;

  // Classify and buffer; ready drops only when the queue is full
  utf8t_front #(
    .CHAR_COUNT_BITS (CHAR_COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .rec_o       (push_rec)
  );

  // Hold finished characters so each side stalls on its own
  utf8t_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (push_rec),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rec_o   (head_rec)
  );

  // Advance through the head record one transfer at a time
  utf8t_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (q_valid),
    .rec_i       (head_rec),
    .pop_o       (q_pop),
    .out_ch      (out_ch)
  );

  // The terminator is always a lone zero byte closing its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.end_of_string) |->
      (out_ch.out_byte == NUL_BYTE && out_ch.last_of_run))
    else $error("top: malformed terminator result");

  // A zero byte always leaves a record waiting in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && in_ch.in_byte == NUL_BYTE) |=> q_valid)
    else $error("top: zero byte produced no terminator record");

endmodule

>>> tb/utf8_char_limit_truncator_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_char_limit_truncator_unit: zero-terminated UTF-8 strings in,
// kept character bytes and terminators out. Needs utf8t_pkg, utf8t_if.sv and the unit itself.
module utf8_char_limit_truncator_unit_tb;
  import utf8t_pkg::*;

  localparam int RANDOM_BYTES     = 96;
  localparam int SETTLE_CYCLES    = 4;     // idle cycles before a limit write
  localparam int LONG_HOLD_CYCLES = 200;   // receiver hold-off under pressure
  localparam int WATCHDOG_LIMIT   = 3000;  // cycles without any transfer
  localparam int TAIL_CYCLES      = 10;
  localparam int MAX_REPORTS      = 100;

  // Entries of the stimulus plan: a byte, a limit write, a pause until drained,
  // or the start of a long receiver hold-off.
  typedef enum logic [1:0] {STEP_BYTE, STEP_LIMIT, STEP_DRAIN, STEP_HOLD} step_kind_e;

  typedef struct {
    step_kind_e  kind;
    logic [15:0] value;
  } stream_step_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       eos;
    logic       last;
  } out_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  utf8t_in_if  in_ch ();
  utf8t_out_if out_ch ();

  utf8_char_limit_truncator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Truncation predictor: its own copy of the string state and the limit
  // ---------------------------------------------------------------------------
  logic [7:0]  held_bytes [3];
  logic [1:0]  held_count;
  logic [1:0]  cont_needed;     // continuation bytes the open lead announced
  logic [15:0] chars_kept;
  logic        string_halted;
  logic [15:0] char_limit;

  out_beat_t    beats_due [$];  // results still owed by the unit, oldest first
  stream_step_t plan [$];       // stimulus waiting for the driver

  int error_count;
  int planned_bytes;
  int idle_cycles;
  int hold_requests;
  int holds_served;
  bit byte_taken;               // input transfer seen at the last rising edge

  task automatic clear_string_state();
    held_count    = '0;
    cont_needed   = '0;
    chars_kept    = '0;
    string_halted = 1'b0;
    for (int i = 0; i < 3; i++) held_bytes[i] = '0;
  endtask

  function automatic logic [15:0] count_up(input logic [15:0] n);
    return (n == 16'hFFFF) ? n : n + 16'd1;
  endfunction

  task automatic truncate_byte(input logic [7:0] b);
    logic [1:0] need;
    if (b == NUL_BYTE) begin
      // Terminator: always emitted, wipes the string state, halted included
      clear_string_state();
      beats_due.push_back('{NUL_BYTE, 1'b1, 1'b1});
    end else if (string_halted) begin
      // Drop everything until the next terminator
    end else if (cont_needed == '0) begin
      if (chars_kept >= char_limit) begin
        string_halted = 1'b1;
      end else if ((b & ASCII_MASK) == ASCII_VAL) begin
        beats_due.push_back('{b, 1'b0, 1'b1});
        chars_kept = count_up(chars_kept);
      end else begin
        if ((b & LEAD2_MASK) == LEAD2_VAL) need = 2'd1;
        else if ((b & LEAD3_MASK) == LEAD3_VAL) need = 2'd2;
        else if ((b & LEAD4_MASK) == LEAD4_VAL) need = 2'd3;
        else need = 2'd0;
        // Stray continuation or a lead of 0xF8 and up ends the output
        if (need == '0) begin
          string_halted = 1'b1;
        end else begin
          held_bytes[0] = b;
          held_count    = 2'd1;
          cont_needed   = need;
        end
      end
    end else if ((b & CONT_MASK) != CONT_VAL) begin
      // Broken sequence: drop the partial character and stop
      held_count    = '0;
      cont_needed   = '0;
      string_halted = 1'b1;
    end else if (held_count >= cont_needed) begin
      // Final continuation: release the whole character at once
      for (int i = 0; i < held_count; i++) beats_due.push_back('{held_bytes[i], 1'b0, 1'b0});
      beats_due.push_back('{b, 1'b0, 1'b1});
      held_count  = '0;
      cont_needed = '0;
      chars_kept  = count_up(chars_kept);
    end else begin
      held_bytes[held_count] = b;
      held_count             = held_count + 2'd1;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic match_out_beat(input logic [7:0] ob, input logic eos, input logic last);
    out_beat_t want;
    if (beats_due.size() == 0) begin
      flag_mismatch($sformatf("result %02h with nothing expected", ob));
    end else begin
      want = beats_due.pop_front();
      if (ob !== want.out_byte)
        flag_mismatch($sformatf("out_byte %02h, expected %02h", ob, want.out_byte));
      if (eos !== want.eos)
        flag_mismatch($sformatf("end_of_string %b, expected %b", eos, want.eos));
      if (last !== want.last)
        flag_mismatch($sformatf("last_of_run %b, expected %b", last, want.last));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Plan building
  // ---------------------------------------------------------------------------
  task automatic add_step(input step_kind_e kind, input logic [15:0] value);
    plan.push_back('{kind, value});
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_step(STEP_BYTE, {8'h00, b});
    planned_bytes++;
  endtask

  task automatic add_cont();
    add_byte(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  // Open a character of len bytes, without its continuation bytes
  task automatic add_lead(input int len);
    case (len)
      1:       add_byte(8'($urandom_range(8'h01, 8'h7F)));
      2:       add_byte(8'($urandom_range(8'hC0, 8'hDF)));
      3:       add_byte(8'($urandom_range(8'hE0, 8'hEF)));
      default: add_byte(8'($urandom_range(8'hF0, 8'hF7)));
    endcase
  endtask

  task automatic add_char(input int len);
    add_lead(len);
    for (int i = 1; i < len; i++) add_cont();
  endtask

  task automatic add_clean_string(input int nchars);
    for (int i = 0; i < nchars; i++) add_char($urandom_range(1, 4));
    add_byte(NUL_BYTE);
  endtask

  // A few good characters, then one fault, then bytes that must be ignored
  task automatic add_broken_string();
    int len;
    for (int i = $urandom_range(0, 3); i > 0; i--) add_char($urandom_range(1, 4));
    len = $urandom_range(2, 4);
    case ($urandom_range(0, 4))
      0: begin
        // End of string inside a sequence
        add_lead(len);
        for (int i = $urandom_range(0, len - 2); i > 0; i--) add_cont();
      end
      1: begin
        // Non-continuation byte inside a sequence
        add_lead(len);
        for (int i = $urandom_range(0, len - 2); i > 0; i--) add_cont();
        if ($urandom_range(0, 1) == 1) add_byte(8'($urandom_range(8'h01, 8'h7F)));
        else add_byte(8'($urandom_range(8'hC0, 8'hFF)));
      end
      2: add_cont();
      3: add_byte(8'($urandom_range(8'hF8, 8'hFF)));
      default: begin
        for (int i = $urandom_range(1, 6); i > 0; i--) add_byte(8'($urandom_range(1, 255)));
      end
    endcase
    for (int i = $urandom_range(0, 2); i > 0; i--) add_char($urandom_range(1, 4));
    add_byte(NUL_BYTE);
  endtask

  task automatic build_plan();
    logic [15:0] limits [6];
    int          phase_end;
    // Directed: every character length at its extremes
    add_byte(8'h7F);
    add_byte(8'hC2); add_byte(8'h80);
    add_byte(8'hEF); add_byte(8'hBF); add_byte(8'hBF);
    add_byte(8'hF4); add_byte(8'h8F); add_byte(8'hBF); add_byte(8'hBF);
    add_byte(NUL_BYTE);
    // Stray continuation byte, then lead of 0xF8 and up
    add_byte(8'h80); add_byte(NUL_BYTE);
    add_byte(8'hFF); add_byte(NUL_BYTE);
    // Bad continuation, and end of string inside a sequence
    add_byte(8'hE2); add_byte(8'h41); add_byte(NUL_BYTE);
    add_byte(8'hF0); add_byte(8'h90); add_byte(NUL_BYTE);
    // Limit of zero stops at the first lead
    add_step(STEP_LIMIT, 16'h0000);
    add_byte(8'h41); add_byte(NUL_BYTE);
    // Limit lowered while a character is open: finish it, then stop
    add_step(STEP_LIMIT, 16'hFFFF);
    add_byte(8'h41); add_byte(8'hC3);
    add_step(STEP_LIMIT, 16'h0001);
    add_byte(8'hA9); add_byte(8'h42); add_byte(NUL_BYTE);

    // Random phases, each under its own limit
    limits[0] = 16'hFFFF;
    limits[1] = 16'($urandom_range(2, 6));
    limits[2] = 16'h0000;
    limits[3] = 16'h0001;
    limits[4] = 16'($urandom_range(0, 65535));
    limits[5] = 16'hFFFF;
    planned_bytes = 0;
    for (int p = 0; p < 6; p++) begin
      add_step(STEP_LIMIT, limits[p]);
      if (p == 0) begin
        // Keep offering a long ASCII string while the receiver holds off
        add_step(STEP_HOLD, 16'h0000);
        for (int i = 0; i < 30; i++) add_char(1);
        add_byte(NUL_BYTE);
      end
      if (p == 3) add_step(STEP_DRAIN, 16'h0000);
      phase_end = (p + 1) * RANDOM_BYTES / 6;
      while (planned_bytes < phase_end) begin
        if ($urandom_range(0, 3) != 0) add_clean_string($urandom_range(0, 8));
        else add_broken_string();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Rising edge: check results, predict accepted bytes, track limit writes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    byte_taken = 1'b0;
    if (rst_ni) begin
      // Check before predicting, so a byte taken now never matches its own result
      if (out_ch.valid && out_ch.ready)
        match_out_beat(out_ch.out_byte, out_ch.end_of_string, out_ch.last_of_run);
      if (in_ch.valid && in_ch.ready) begin
        byte_taken = 1'b1;
        truncate_byte(in_ch.in_byte);
      end
      if (cfg_we_i) char_limit = cfg_wdata_i;

      if ((out_ch.valid && out_ch.ready) || byte_taken || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte driver: bursts and gaps, limit writes only while the unit is idle
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;
  int steady_left;
  int settle_count;

  always @(negedge clk_i) begin : drive_bytes
    logic        next_valid;
    logic [7:0]  next_byte;
    logic        next_we;
    logic [15:0] next_wdata;
    next_valid = in_ch.valid;
    next_byte  = in_ch.in_byte;
    next_we    = 1'b0;
    next_wdata = cfg_wdata_i;
    if (!(in_ch.valid && !byte_taken)) begin
      // Previous byte transferred, or none offered: pick the next step
      next_valid = 1'b0;
      if (rst_ni && plan.size() > 0) begin
        case (plan[0].kind)
          STEP_BYTE: begin
            if (gap_left > 0 && steady_left == 0) begin
              gap_left--;
            end else begin
              next_valid = 1'b1;
              next_byte  = plan[0].value[7:0];
              void'(plan.pop_front());
              if (steady_left > 0) steady_left--;
              if (burst_left > 0) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(0, 12);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
              end
            end
          end
          STEP_HOLD: begin
            hold_requests++;
            steady_left = 32;
            void'(plan.pop_front());
          end
          default: begin
            // Limit write or drain pause: wait for every result plus a settle time
            if (beats_due.size() == 0) settle_count++;
            else settle_count = 0;
            if (settle_count >= SETTLE_CYCLES) begin
              settle_count = 0;
              if (plan[0].kind == STEP_LIMIT) begin
                next_we    = 1'b1;
                next_wdata = plan[0].value;
              end
              void'(plan.pop_front());
            end
          end
        endcase
      end
    end
    in_ch.valid   <= next_valid;
    in_ch.in_byte <= next_byte;
    cfg_we_i      <= next_we;
    cfg_wdata_i   <= next_wdata;
  end

  // ---------------------------------------------------------------------------
  // Result receiver: its own stall pattern, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  int       hold_left;
  int       mode_left;
  int       rx_mode;
  int       rx_phase;
  bit [4:0] rx_pattern = 5'b10110;

  always @(negedge clk_i) begin : pace_results
    logic take;
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = LONG_HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      mode_left = $urandom_range(10, 60);
    end else begin
      mode_left--;
    end
    rx_phase = (rx_phase + 1) % 5;
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else begin
      case (rx_mode)
        0:       take = 1'b1;
        1:       take = 1'($urandom_range(0, 1));
        2:       take = ($urandom_range(0, 3) == 0);
        default: take = rx_pattern[rx_phase];
      endcase
    end
    out_ch.ready <= take;
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, run the plan, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    out_ch.ready   = 1'b0;
    error_count    = 0;
    idle_cycles    = 0;
    hold_requests  = 0;
    holds_served   = 0;
    burst_left     = 0;
    gap_left       = 0;
    steady_left    = 0;
    settle_count   = 0;
    hold_left      = 0;
    mode_left      = 0;
    rx_mode        = 0;
    rx_phase       = 0;
    char_limit     = LIMIT_RESET;
    clear_string_state();
    build_plan();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every byte to transfer, then for every result to arrive
    while (plan.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0 && beats_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
